### src/lrd_pkg.sv
// Shared types and codes for the lockset race detector.
// Fixed field widths, operation and race codes, and the lock and access request structs.
// No dependencies.
package lrd_pkg;

    // Field widths of the event and result items
    localparam int OP_W     = 3;
    localparam int THREAD_W = 4;
    localparam int LOCK_W   = 5;
    localparam int VAR_W    = 10;
    localparam int INSTR_W  = 32;

    // Trace event operations
    typedef enum logic [OP_W-1:0] {
        OP_NEW_THREAD = 3'd0,
        OP_ACQUIRE    = 3'd1,
        OP_RELEASE    = 3'd2,
        OP_READ       = 3'd3,
        OP_WRITE      = 3'd4
    } t_op;

    // Race kinds reported in the result item
    localparam logic RACE_WRITE_READ  = 1'b0;
    localparam logic RACE_WRITE_WRITE = 1'b1;

    // Held-lock table update request
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [THREAD_W-1:0] thread;
        logic [THREAD_W-1:0] child_thread;
        logic [LOCK_W-1:0]   lock_index;
    } t_lock_req;

    // Variable access request handed to the variable unit
    typedef struct packed {
        logic                is_write;
        logic [VAR_W-1:0]    variable;
        logic [INSTR_W-1:0]  instruction;
    } t_acc_req;

endpackage

### src/lrd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first: a read and a write to one address on the same edge return old data.
// No dependencies.
module lrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lrd_lock_table.sv
// Per-thread held-lock masks: fork copy, acquire and release, and mask lookup.
// Depends on lrd_pkg.
module lrd_lock_table #(
    parameter int NUM_THREADS = 16,
    parameter int NUM_LOCKS   = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  lrd_pkg::t_lock_req    i_req,
    output logic [NUM_LOCKS-1:0]  o_mine
);

    localparam int THR_AW = $clog2(NUM_THREADS);

    logic [NUM_LOCKS-1:0] r_held [NUM_THREADS];
    logic [THR_AW-1:0]    w_thr_idx;
    logic [THR_AW-1:0]    w_child_idx;
    logic                 w_thr_ok;
    logic                 w_child_ok;
    logic                 w_lock_ok;
    logic [NUM_LOCKS-1:0] w_lock_bit;
    logic [NUM_LOCKS-1:0] w_mine;

    // Range checks and indexes
    assign w_thr_ok    = 32'(i_req.thread) < NUM_THREADS;
    assign w_child_ok  = 32'(i_req.child_thread) < NUM_THREADS;
    assign w_lock_ok   = 32'(i_req.lock_index) < NUM_LOCKS;
    assign w_thr_idx   = THR_AW'(i_req.thread);
    assign w_child_idx = THR_AW'(i_req.child_thread);
    assign w_lock_bit  = NUM_LOCKS'(1) << i_req.lock_index;

    // Out-of-range thread holds no locks
    assign w_mine = w_thr_ok ? r_held[w_thr_idx] : '0;
    assign o_mine = w_mine;

    // Mask updates on accepted events
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                r_held[i] <= '0;
            end
        end else if (i_en) begin
            unique case (i_req.op)
                lrd_pkg::OP_NEW_THREAD: begin
                    if (w_child_ok) begin
                        r_held[w_child_idx] <= w_mine;
                    end
                end
                lrd_pkg::OP_ACQUIRE: begin
                    if (w_thr_ok && w_lock_ok) begin
                        r_held[w_thr_idx] <= r_held[w_thr_idx] | w_lock_bit;
                    end
                end
                lrd_pkg::OP_RELEASE: begin
                    if (w_thr_ok && w_lock_ok) begin
                        r_held[w_thr_idx] <= r_held[w_thr_idx] & ~w_lock_bit;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### src/lrd_var_unit.sv
// Per-variable state in one RAM: write lockset, last write instruction, written flag.
// Read-modify-write stage with forwarding, clearing pass, race check, result register.
// Depends on lrd_pkg and lrd_ram.
module lrd_var_unit #(
    parameter int NUM_LOCKS = 32,
    parameter int NUM_VARS  = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc_valid,
    input  lrd_pkg::t_acc_req     i_acc,
    input  logic [NUM_LOCKS-1:0]  i_mine,
    output logic                  o_ready,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [79:0]           o_m_axis_tdata,  // first_instruction, second_instruction,
                                                   // race_variable, zero pad
    output logic [0:0]            o_m_axis_tuser   // race_kind
);

    localparam int VAR_AW = $clog2(NUM_VARS);
    // Word layout from bit 0: lockset, last write instruction, written flag
    localparam int WORD_W = NUM_LOCKS + lrd_pkg::INSTR_W + 1;
    localparam int FLAG_B = WORD_W - 1;

    // Clearing pass
    logic              r_clr_busy;
    logic [VAR_AW-1:0] r_clr_addr;

    // Access stage
    logic                     r_s1_valid;
    lrd_pkg::t_acc_req        r_s1_req;
    logic [NUM_LOCKS-1:0]     r_s1_mine;
    logic                     r_fwd_hit;
    logic [WORD_W-1:0]        r_fwd_word;

    // Result register
    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [lrd_pkg::INSTR_W-1:0]   r_out_first;
    logic [lrd_pkg::INSTR_W-1:0]   r_out_second;
    logic [lrd_pkg::VAR_W-1:0]     r_out_var;

    logic [WORD_W-1:0]             w_rdata;
    logic [WORD_W-1:0]             w_cur;
    logic                          w_flag;
    logic [NUM_LOCKS-1:0]          w_ls;
    logic [lrd_pkg::INSTR_W-1:0]   w_prev;
    logic [NUM_LOCKS-1:0]          n_ls;
    logic [WORD_W-1:0]             n_word;
    logic                          w_stall;
    logic                          w_advance;
    logic                          w_wr;
    logic                          w_race_ww;
    logic                          w_race_wr;
    logic [VAR_AW-1:0]             w_s1_addr;
    logic [VAR_AW-1:0]             w_in_addr;
    logic                          w_we;
    logic [VAR_AW-1:0]             w_waddr;
    logic [WORD_W-1:0]             w_wdata;

    assign w_s1_addr = VAR_AW'(r_s1_req.variable);
    assign w_in_addr = VAR_AW'(i_acc.variable);

    // Stage holds while the result register is full and not taken
    assign w_stall   = r_s1_valid && r_out_valid && !i_m_axis_tready;
    assign w_advance = r_s1_valid && !w_stall;
    assign o_ready   = !r_clr_busy && !w_stall;

    // Current entry: forwarded word if the previous write hit this entry on our read edge
    assign w_cur  = r_fwd_hit ? r_fwd_word : w_rdata;
    assign w_flag = w_cur[FLAG_B];
    assign w_ls   = w_cur[NUM_LOCKS-1:0];
    assign w_prev = w_cur[NUM_LOCKS +: lrd_pkg::INSTR_W];

    // Lockset narrowing; first write starts from all locks
    assign n_ls      = w_flag ? (w_ls & r_s1_mine) : r_s1_mine;
    assign n_word    = {1'b1, r_s1_req.instruction, n_ls};
    assign w_wr      = w_advance && r_s1_req.is_write;
    assign w_race_ww = r_s1_req.is_write && w_flag && (n_ls == '0);
    assign w_race_wr = !r_s1_req.is_write && w_flag && ((w_ls & r_s1_mine) == '0);

    // RAM write port: clearing pass or write-back
    assign w_we    = r_clr_busy || w_wr;
    assign w_waddr = r_clr_busy ? r_clr_addr : w_s1_addr;
    assign w_wdata = r_clr_busy ? '0 : n_word;

    lrd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_VARS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_acc_valid),
        .i_raddr (w_in_addr),
        .o_rdata (w_rdata)
    );

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + VAR_AW'(1);
            if (r_clr_addr == VAR_AW'(NUM_VARS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Access stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_acc_valid) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Access stage payload and forwarding capture
    always_ff @(posedge i_clk) begin
        if (i_acc_valid) begin
            r_s1_req   <= i_acc;
            r_s1_mine  <= i_mine;
            r_fwd_hit  <= w_wr && (w_s1_addr == w_in_addr);
            r_fwd_word <= n_word;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && (w_race_ww || w_race_wr)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && (w_race_ww || w_race_wr)) begin
            r_out_kind   <= w_race_ww ? lrd_pkg::RACE_WRITE_WRITE
                                      : lrd_pkg::RACE_WRITE_READ;
            r_out_first  <= w_prev;
            r_out_second <= r_s1_req.instruction;
            r_out_var    <= r_s1_req.variable;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_var, r_out_second, r_out_first};
    assign o_m_axis_tuser  = r_out_kind;

endmodule

### src/lockset_race_detector.sv
// A racing access passes the access stage register and then the result register.
// Throughput: one event per cycle while the result side keeps up; a stalled result
// blocks new events once the variable stage holds an access.
// Rate is set by the per-variable RAM read-modify-write, with one-deep forwarding.
// Reset: synchronous active low; afterward a clearing pass writes NUM_VARS entries,
// during which no event is accepted.
// Top level: event decode, held-lock table and variable unit. Depends on lrd_pkg,
// lrd_lock_table and lrd_var_unit.
module lockset_race_detector #(
    parameter int NUM_THREADS = 16,
    parameter int NUM_LOCKS   = 32,
    parameter int NUM_VARS    = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // thread, child_thread, lock_index, variable,
                                          // instruction, zero pad
    input  logic [3:0]  i_s_axis_tuser,   // op, on_stack
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // first_instruction, second_instruction,
                                          // race_variable, zero pad
    output logic [0:0]  o_m_axis_tuser    // race_kind
);

    logic                       w_accept;
    logic [lrd_pkg::OP_W-1:0]   w_op;
    logic                       w_on_stack;
    logic [lrd_pkg::VAR_W-1:0]  w_var;
    logic                       w_is_access;
    logic                       w_var_ok;
    logic                       w_acc_valid;
    lrd_pkg::t_lock_req         w_lock_req;
    lrd_pkg::t_acc_req          w_acc;
    logic [NUM_LOCKS-1:0]       w_mine;

    // Event field unpacking
    assign w_op       = i_s_axis_tuser[2:0];
    assign w_on_stack = i_s_axis_tuser[3];
    assign w_var      = i_s_axis_tdata[22:13];

    assign w_lock_req.op           = w_op;
    assign w_lock_req.thread       = i_s_axis_tdata[3:0];
    assign w_lock_req.child_thread = i_s_axis_tdata[7:4];
    assign w_lock_req.lock_index   = i_s_axis_tdata[12:8];

    assign w_acc.is_write    = (w_op == lrd_pkg::OP_WRITE);
    assign w_acc.variable    = w_var;
    assign w_acc.instruction = i_s_axis_tdata[54:23];

    // Only heap accesses in range reach the variable unit
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_access = (w_op == lrd_pkg::OP_READ) || (w_op == lrd_pkg::OP_WRITE);
    assign w_var_ok    = 32'(w_var) < NUM_VARS;
    assign w_acc_valid = w_accept && w_is_access && !w_on_stack && w_var_ok;

    lrd_lock_table #(
        .NUM_THREADS (NUM_THREADS),
        .NUM_LOCKS   (NUM_LOCKS)
    ) u_locks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_req   (w_lock_req),
        .o_mine  (w_mine)
    );

    lrd_var_unit #(
        .NUM_LOCKS (NUM_LOCKS),
        .NUM_VARS  (NUM_VARS)
    ) u_vars (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_acc_valid     (w_acc_valid),
        .i_acc           (w_acc),
        .i_mine          (w_mine),
        .o_ready         (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

### src/lrd_checker.sv
// Port-level checks for the lockset race detector, bound to the top level.
// Depends on lrd_pkg and lockset_race_detector.
module lrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [55:0] i_s_axis_tdata,
    input logic [3:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    logic w_in_acc;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result item changed while stalled");

    // Clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready during clearing pass");

    // A fresh result carries the instruction and variable of the access that produced it
    a_second_instr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(w_in_acc, 2) && o_m_axis_tdata[63:32] == $past(i_s_axis_tdata[54:23], 2)
            && o_m_axis_tdata[73:64] == $past(i_s_axis_tdata[22:13], 2))
        else $error("result does not match its access");

    // Race kind follows the access operation
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            (o_m_axis_tuser[0] == lrd_pkg::RACE_WRITE_WRITE) ==
            ($past(i_s_axis_tuser[2:0], 2) == lrd_pkg::OP_WRITE))
        else $error("race kind does not match operation");

endmodule

bind lockset_race_detector lrd_checker u_lrd_checker (.*);
